### rtl/ssbk_pkg.sv
// Shared types, codes and constants of the stable sort and batch block.
package ssbk_pkg;

	localparam int MAX_ENTRIES_DEF = 32;
	localparam int TEX_W = 32;
	localparam int DEP_W = 32;
	localparam int INDEX_W = 5;
	localparam int VTX_W = 8;
	localparam int MODE_W = 2;
	localparam logic [VTX_W-1:0] VERTS_PER_ENTRY = 8'd6;

	localparam logic [MODE_W-1:0] MODE_TEX_UP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEP_UP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DEP_DOWN = 2'd2;

	localparam logic KIND_ENTRY = 1'b0;
	localparam logic KIND_BATCH = 1'b1;

	typedef struct packed {
		logic [TEX_W-1:0] tex;
		logic [DEP_W-1:0] dep;
	} key_t;

endpackage

### rtl/ssbk_ram.sv
// Generic single write port RAM with one registered read port.
module ssbk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/ssbk_cmp.sv
// Shared key comparator: decides whether entry a goes strictly before entry b.
module ssbk_cmp
	import ssbk_pkg::*;
(
	input  logic [MODE_W-1:0] mode,
	input  key_t              a,
	input  key_t              b,
	output logic              ahead
);

	logic [DEP_W-1:0] da;
	logic [DEP_W-1:0] db;

	// Flipping the sign bit turns a signed compare into an unsigned one.
	assign da = {~a.dep[DEP_W-1], a.dep[DEP_W-2:0]};
	assign db = {~b.dep[DEP_W-1], b.dep[DEP_W-2:0]};

	always_comb begin
		unique case (mode)
			MODE_TEX_UP: ahead = a.tex < b.tex;
			MODE_DEP_UP: ahead = da < db;
			MODE_DEP_DOWN: ahead = da > db;
			default: ahead = 1'b0;
		endcase
	end

endmodule

### rtl/stable_sort_and_batch_by_key.sv
// Top level of the stable sort and batch block: loader, sort sequencer and output stage.
//
// Entries arrive on the input channel (in_valid/in_ready) one request per cycle while
// the block is loading. Each is written to the texture and depth RAMs; once MAX_ENTRIES
// are held, further entries are dropped and the overflow flag is set. An entry with
// last_entry set ends the set and closes the input channel until all records are out.
// Sorting is an insertion sort run by a small sequencer around one shared comparator:
// each compare step reads the index RAM, then the key RAM, then compares and writes
// back. Output then reads the index RAM and the key RAM for each entry record and
// sends one record per request on the output channel (out_valid/out_ready). The record
// is held in an output register; a stalled receiver freezes the sequencer, nothing is
// lost. The sort_mode port is written through cfg_valid/cfg_ready and takes effect at
// once; the user must write it only while loading for it to apply to the next completed
// set, as the block itself does not enforce this. Reset clears the entry count, the
// overflow flag and sort_mode; the entry RAMs are not cleared and need no clearing pass.
module stable_sort_and_batch_by_key
	import ssbk_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [MODE_W-1:0]       sort_mode,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [TEX_W-1:0]        texture_id,
	input  logic signed [DEP_W-1:0] depth,
	input  logic                    last_entry,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    kind,
	output logic [INDEX_W-1:0]      entry_index,
	output logic [TEX_W-1:0]        batch_texture,
	output logic [VTX_W-1:0]        vertex_offset,
	output logic [VTX_W-1:0]        vertex_count,
	output logic                    overflowed,
	output logic                    last_result
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_SORT_CUR = 4'd1;
	localparam logic [3:0] ST_SORT_LAT = 4'd2;
	localparam logic [3:0] ST_SORT_STEP = 4'd3;
	localparam logic [3:0] ST_SORT_KEY = 4'd4;
	localparam logic [3:0] ST_SORT_CMP = 4'd5;
	localparam logic [3:0] ST_OUT_RD = 4'd6;
	localparam logic [3:0] ST_OUT_KEY = 4'd7;
	localparam logic [3:0] ST_OUT_EMIT = 4'd8;
	localparam logic [3:0] ST_OUT_FINAL = 4'd9;

	logic [3:0]        state_q;
	logic [MODE_W-1:0] mode_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  e_q;
	key_t              cur_q;
	logic [CNT_W-1:0]  p_q;
	logic [VTX_W-1:0]  vtx_q;
	logic [VTX_W-1:0]  run_vtx_q;
	logic [TEX_W-1:0]  run_tex_q;

	logic              out_valid_q;
	logic              kind_q;
	logic [INDEX_W-1:0] entry_index_q;
	logic [TEX_W-1:0]  batch_texture_q;
	logic [VTX_W-1:0]  vertex_offset_q;
	logic [VTX_W-1:0]  vertex_count_q;
	logic              overflowed_q;
	logic              last_result_q;

	logic              accept;
	logic              has_room;
	logic              slot_free;
	logic              key_we;
	logic [IDX_W-1:0]  key_raddr;
	logic              idx_we;
	logic [IDX_W-1:0]  idx_waddr;
	logic [IDX_W-1:0]  idx_wdata;
	logic [IDX_W-1:0]  idx_raddr;
	logic [TEX_W-1:0]  tex_rd;
	logic [DEP_W-1:0]  dep_rd;
	logic [IDX_W-1:0]  idx_rd;
	key_t              rd_key;
	logic              ahead;
	logic              new_run;
	logic              emit_entry;
	logic              emit_batch;
	logic              emit_final;
	logic [CNT_W-1:0]  p_nxt;
	logic [CNT_W-1:0]  i_nxt;

	assign cfg_ready = 1'b1;
	assign in_ready = state_q == ST_LOAD;
	assign accept = in_valid && in_ready;
	assign has_room = count_q < CNT_W'(MAX_ENTRIES);
	assign key_we = accept && has_room;
	assign slot_free = !out_valid_q || out_ready;
	assign rd_key = '{tex: tex_rd, dep: dep_rd};
	assign p_nxt = p_q + CNT_W'(1);
	assign i_nxt = i_q + CNT_W'(1);
	assign new_run = (p_q != '0) && (tex_rd != run_tex_q);
	assign emit_batch = (state_q == ST_OUT_EMIT) && slot_free && new_run;
	assign emit_entry = (state_q == ST_OUT_EMIT) && slot_free && !new_run;
	assign emit_final = (state_q == ST_OUT_FINAL) && slot_free;

	always_comb begin
		unique case (state_q)
			ST_SORT_CUR: key_raddr = i_q[IDX_W-1:0];
			ST_SORT_KEY, ST_OUT_KEY: key_raddr = idx_rd;
			default: key_raddr = e_q;
		endcase
	end

	always_comb begin
		idx_raddr = p_q[IDX_W-1:0];
		idx_we = 1'b0;
		idx_waddr = j_q;
		idx_wdata = i_q[IDX_W-1:0];
		unique case (state_q)
			ST_SORT_STEP: begin
				idx_raddr = j_q - IDX_W'(1);
				idx_we = j_q == '0;
			end
			ST_SORT_CMP: begin
				idx_we = 1'b1;
				idx_wdata = ahead ? e_q : i_q[IDX_W-1:0];
			end
			default: begin
				idx_we = 1'b0;
			end
		endcase
	end

	ssbk_ram #(.WIDTH(TEX_W), .DEPTH(MAX_ENTRIES)) u_tex_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (texture_id),
		.raddr (key_raddr),
		.rdata (tex_rd)
	);

	ssbk_ram #(.WIDTH(DEP_W), .DEPTH(MAX_ENTRIES)) u_dep_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (depth),
		.raddr (key_raddr),
		.rdata (dep_rd)
	);

	ssbk_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_idx_ram (
		.clk   (clk),
		.we    (idx_we),
		.waddr (idx_waddr),
		.wdata (idx_wdata),
		.raddr (idx_raddr),
		.rdata (idx_rd)
	);

	ssbk_cmp u_cmp (
		.mode  (mode_q),
		.a     (cur_q),
		.b     (rd_key),
		.ahead (ahead)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEX_UP;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= sort_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			p_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_entry) begin
							i_q <= '0;
							state_q <= ST_SORT_CUR;
						end
					end
				end
				ST_SORT_CUR: begin
					if (i_q == count_q) begin
						p_q <= '0;
						state_q <= ST_OUT_RD;
					end else begin
						state_q <= ST_SORT_LAT;
					end
				end
				ST_SORT_LAT: begin
					j_q <= i_q[IDX_W-1:0];
					state_q <= ST_SORT_STEP;
				end
				ST_SORT_STEP: begin
					if (j_q == '0) begin
						i_q <= i_nxt;
						state_q <= ST_SORT_CUR;
					end else begin
						state_q <= ST_SORT_KEY;
					end
				end
				ST_SORT_KEY: begin
					state_q <= ST_SORT_CMP;
				end
				ST_SORT_CMP: begin
					if (ahead) begin
						j_q <= j_q - IDX_W'(1);
						state_q <= ST_SORT_STEP;
					end else begin
						i_q <= i_nxt;
						state_q <= ST_SORT_CUR;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_KEY;
				end
				ST_OUT_KEY: begin
					state_q <= ST_OUT_EMIT;
				end
				ST_OUT_EMIT: begin
					if (emit_entry) begin
						p_q <= p_nxt;
						state_q <= (p_nxt == count_q) ? ST_OUT_FINAL : ST_OUT_RD;
					end
				end
				ST_OUT_FINAL: begin
					if (emit_final) begin
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SORT_LAT) begin
			cur_q <= rd_key;
		end
		if (state_q == ST_SORT_KEY || state_q == ST_OUT_KEY) begin
			e_q <= idx_rd;
		end
		if (state_q == ST_SORT_CUR) begin
			vtx_q <= '0;
			run_vtx_q <= '0;
		end else if (emit_entry) begin
			vtx_q <= vtx_q + VERTS_PER_ENTRY;
			run_tex_q <= tex_rd;
		end else if (emit_batch) begin
			run_vtx_q <= vtx_q;
			run_tex_q <= tex_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_entry || emit_batch || emit_final) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_entry) begin
			kind_q <= KIND_ENTRY;
			entry_index_q <= INDEX_W'(e_q);
			batch_texture_q <= tex_rd;
			vertex_offset_q <= vtx_q;
			vertex_count_q <= '0;
			overflowed_q <= ovf_q;
			last_result_q <= 1'b0;
		end else if (emit_batch || emit_final) begin
			kind_q <= KIND_BATCH;
			entry_index_q <= '0;
			batch_texture_q <= run_tex_q;
			vertex_offset_q <= run_vtx_q;
			vertex_count_q <= vtx_q - run_vtx_q;
			overflowed_q <= ovf_q;
			last_result_q <= emit_final;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign entry_index = entry_index_q;
	assign batch_texture = batch_texture_q;
	assign vertex_offset = vertex_offset_q;
	assign vertex_count = vertex_count_q;
	assign overflowed = overflowed_q;
	assign last_result = last_result_q;

endmodule

### rtl/ssbk_chk.sv
// Port-level checker for the stable sort and batch block, with its bind statement.
module ssbk_chk
	import ssbk_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    last_entry,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    kind,
	input logic [INDEX_W-1:0]      entry_index,
	input logic [TEX_W-1:0]        batch_texture,
	input logic [VTX_W-1:0]        vertex_offset,
	input logic [VTX_W-1:0]        vertex_count,
	input logic                    overflowed,
	input logic                    last_result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(entry_index)
			&& $stable(batch_texture) && $stable(vertex_offset) && $stable(vertex_count)
			&& $stable(overflowed) && $stable(last_result))
		else $error("Stalled output request changed.");

	a_entry_rec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ENTRY |-> vertex_count == '0 && !last_result)
		else $error("Entry record carries a vertex count or the last mark.");

	a_batch_rec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BATCH |-> entry_index == '0 && vertex_count != '0)
		else $error("Batch record is malformed.");

	a_set_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_entry |=> !in_ready)
		else $error("Input stayed open after the last entry of a set.");

endmodule

bind stable_sort_and_batch_by_key ssbk_chk u_ssbk_chk (.*);

### test/testbench.sv
// Self-checking testbench for the stable sort and batch block: directed sets, then random sets.
`timescale 1ns / 100ps

module testbench;
	import ssbk_pkg::*;

	localparam logic [MODE_W-1:0] MODE_ARRIVAL = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ENTRIES = 80;

	typedef struct packed {
		logic kind;
		logic [INDEX_W-1:0] idx;
		logic [TEX_W-1:0] tex;
		logic [VTX_W-1:0] off;
		logic [VTX_W-1:0] cnt;
		logic ovf;
		logic fin;
	} record_t;

	typedef struct packed {
		logic new_mode;
		logic [MODE_W-1:0] mode;
		logic [TEX_W-1:0] tex;
		logic [DEP_W-1:0] dep;
		logic fin;
		logic typed;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [MODE_W-1:0] sort_mode;
	logic in_valid;
	logic in_ready;
	logic [TEX_W-1:0] texture_id;
	logic signed [DEP_W-1:0] depth;
	logic last_entry;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind;
	logic [INDEX_W-1:0] entry_index;
	logic [TEX_W-1:0] batch_texture;
	logic [VTX_W-1:0] vertex_offset;
	logic [VTX_W-1:0] vertex_count;
	logic overflowed;
	logic last_result;

	logic [TEX_W-1:0] tex_mem [MAX_ENTRIES_DEF];
	logic signed [DEP_W-1:0] dep_mem [MAX_ENTRIES_DEF];
	int held_entries = 0;
	logic spilled = 1'b0;
	logic [MODE_W-1:0] mode_now = MODE_TEX_UP;
	bit steady = 1'b0;

	record_t expected_records [$];
	int mismatches = 0;
	int records_checked = 0;
	int entries_sent = 0;
	int sets_done = 0;
	int overflow_sets = 0;
	bit [3:0] modes_seen = '0;
	int stall_cycles = 0;

	row_t directed_rows [0:18] = '{
		'{1'b0, MODE_TEX_UP,   32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
		'{1'b0, MODE_TEX_UP,   32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1},
		'{1'b1, MODE_DEP_UP,   32'h0000_0005, 32'h8000_0000, 1'b0, 1'b0},
		'{1'b0, MODE_DEP_UP,   32'h0000_0005, 32'h7FFF_FFFF, 1'b0, 1'b0},
		'{1'b0, MODE_DEP_UP,   32'h0000_0007, 32'h0000_0000, 1'b0, 1'b0},
		'{1'b0, MODE_DEP_UP,   32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0},
		'{1'b0, MODE_DEP_UP,   32'h0000_0007, 32'hFFFF_FFFF, 1'b1, 1'b0},
		'{1'b1, MODE_DEP_DOWN, 32'h0000_0003, 32'h0000_0064, 1'b0, 1'b0},
		'{1'b0, MODE_DEP_DOWN, 32'h0000_0003, 32'h0000_0064, 1'b0, 1'b0},
		'{1'b0, MODE_DEP_DOWN, 32'h0000_0009, 32'h8000_0000, 1'b0, 1'b0},
		'{1'b0, MODE_DEP_DOWN, 32'h0000_0003, 32'h7FFF_FFFF, 1'b1, 1'b0},
		'{1'b1, MODE_ARRIVAL,  32'h0000_0002, 32'h0000_0001, 1'b0, 1'b0},
		'{1'b0, MODE_ARRIVAL,  32'h0000_0001, 32'h0000_0002, 1'b0, 1'b0},
		'{1'b0, MODE_ARRIVAL,  32'h0000_0001, 32'h0000_0003, 1'b1, 1'b0},
		'{1'b1, MODE_TEX_UP,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0},
		'{1'b0, MODE_TEX_UP,   32'h0000_0000, 32'h0000_0005, 1'b0, 1'b0},
		'{1'b0, MODE_TEX_UP,   32'h8000_0000, 32'h0000_0009, 1'b0, 1'b0},
		'{1'b0, MODE_TEX_UP,   32'h0000_0000, 32'h0000_0007, 1'b0, 1'b0},
		'{1'b0, MODE_TEX_UP,   32'hFFFF_FFFF, 32'hFFFF_0000, 1'b1, 1'b0}
	};

	stable_sort_and_batch_by_key uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.sort_mode(sort_mode),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.texture_id(texture_id),
		.depth(depth),
		.last_entry(last_entry),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.entry_index(entry_index),
		.batch_texture(batch_texture),
		.vertex_offset(vertex_offset),
		.vertex_count(vertex_count),
		.overflowed(overflowed),
		.last_result(last_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit take_break();
		return !steady && ($urandom_range(0, 99) < 14);
	endfunction

	task automatic note_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			note_mismatch($sformatf("record %0d: %s is %0h, expected %0h",
				records_checked, name, got, want));
		end
	endtask

	function automatic bit sorts_ahead(input int a, input int b);
		case (mode_now)
			MODE_TEX_UP: return tex_mem[a] < tex_mem[b];
			MODE_DEP_UP: return dep_mem[a] < dep_mem[b];
			MODE_DEP_DOWN: return dep_mem[a] > dep_mem[b];
			default: return 1'b0;
		endcase
	endfunction

	// Stable insertion sort of arrival positions, then one entry record per position and a
	// batch record closing every run of equal textures.
	task automatic queue_sorted_records();
		int order [MAX_ENTRIES_DEF];
		int cur;
		int j;
		int run_start;
		int e;
		record_t r;
		for (int i = 0; i < held_entries; i++) begin
			order[i] = i;
		end
		for (int i = 1; i < held_entries; i++) begin
			cur = order[i];
			j = i;
			while (j > 0 && sorts_ahead(cur, order[j-1])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = cur;
		end
		run_start = 0;
		for (int p = 0; p < held_entries; p++) begin
			e = order[p];
			r = '{KIND_ENTRY, e[INDEX_W-1:0], tex_mem[e], VTX_W'(p * VERTS_PER_ENTRY), '0,
				spilled, 1'b0};
			expected_records.push_back(r);
			if (p + 1 == held_entries || tex_mem[order[p+1]] != tex_mem[e]) begin
				r.kind = KIND_BATCH;
				r.idx = '0;
				r.off = VTX_W'(run_start * VERTS_PER_ENTRY);
				r.cnt = VTX_W'((p + 1 - run_start) * VERTS_PER_ENTRY);
				r.fin = (p + 1 == held_entries);
				expected_records.push_back(r);
				run_start = p + 1;
			end
		end
	endtask

	task automatic model_entry(input logic [TEX_W-1:0] tex, input logic [DEP_W-1:0] dep,
			input logic fin, input logic typed);
		if (held_entries < MAX_ENTRIES_DEF) begin
			tex_mem[held_entries] = tex;
			dep_mem[held_entries] = dep;
			held_entries++;
		end else begin
			spilled = 1'b1;
		end
		if (fin) begin
			if (spilled) begin
				overflow_sets++;
			end
			if (!typed) begin
				queue_sorted_records();
			end
			modes_seen[mode_now] = 1'b1;
			held_entries = 0;
			spilled = 1'b0;
			sets_done++;
		end
	endtask

	task automatic push_entry(input logic [TEX_W-1:0] tex, input logic [DEP_W-1:0] dep,
			input logic fin, input logic typed);
		while (take_break()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		texture_id <= tex;
		depth <= dep;
		last_entry <= fin;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		model_entry(tex, dep, fin, typed);
		entries_sent++;
		@(negedge clk);
	endtask

	task automatic set_mode(input logic [MODE_W-1:0] m);
		cfg_valid <= 1'b1;
		sort_mode <= m;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		mode_now = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic await_set_records();
		in_valid <= 1'b0;
		while (expected_records.size() != 0) begin
			@(negedge clk);
		end
		repeat (10) @(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ready <= !take_break();
	end

	always @(posedge clk) begin
		record_t got;
		record_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{kind, entry_index, batch_texture, vertex_offset, vertex_count, overflowed,
				last_result};
			if (expected_records.size() == 0) begin
				note_mismatch($sformatf("record with nothing pending: kind %0d texture %0h",
					got.kind, got.tex));
			end else begin
				want = expected_records.pop_front();
				compare_field("kind", 32'(got.kind), 32'(want.kind));
				compare_field("entry_index", 32'(got.idx), 32'(want.idx));
				compare_field("batch_texture", got.tex, want.tex);
				compare_field("vertex_offset", 32'(got.off), 32'(want.off));
				compare_field("vertex_count", 32'(got.cnt), 32'(want.cnt));
				compare_field("overflowed", 32'(got.ovf), 32'(want.ovf));
				compare_field("last_result", 32'(got.fin), 32'(want.fin));
			end
			records_checked++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles.", STALL_LIMIT);
			$display("stable_sort_and_batch_by_key regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stimulus
		row_t row;
		record_t r;
		int set_no;
		int size;
		int random_entries;
		logic [TEX_W-1:0] tex;
		logic [DEP_W-1:0] dep;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		sort_mode = MODE_TEX_UP;
		in_valid = 1'b0;
		texture_id = '0;
		depth = '0;
		last_entry = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A single-entry set yields one entry record and one closing batch of six vertices.
		for (int i = 0; i < $size(directed_rows); i++) begin
			row = directed_rows[i];
			if (row.new_mode) begin
				set_mode(row.mode);
			end
			if (row.typed) begin
				r = '{KIND_ENTRY, 5'd0, row.tex, 8'd0, 8'd0, 1'b0, 1'b0};
				expected_records.push_back(r);
				r = '{KIND_BATCH, 5'd0, row.tex, 8'd0, 8'd6, 1'b0, 1'b1};
				expected_records.push_back(r);
			end
			push_entry(row.tex, row.dep, row.fin, row.typed);
			if (row.fin) begin
				await_set_records();
			end
		end

		set_no = 0;
		random_entries = 0;
		while (random_entries < RANDOM_ENTRIES) begin
			steady = (set_no >= 4 && set_no < 7);
			if ($urandom_range(0, 9) < 7) begin
				set_mode(MODE_W'($urandom_range(0, 3)));
			end
			if (set_no == 2) begin
				size = $urandom_range(MAX_ENTRIES_DEF + 1, MAX_ENTRIES_DEF + 3);
			end else if ($urandom_range(0, 7) == 0) begin
				size = $urandom_range(9, MAX_ENTRIES_DEF);
			end else begin
				size = $urandom_range(1, 8);
			end
			for (int k = 0; k < size; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: tex = $urandom_range(0, 3);
					8: tex = 32'hFFFF_FFFF;
					default: tex = $urandom;
				endcase
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: dep = $urandom_range(0, 6) - 3;
					8: dep = 32'h8000_0000;
					9: dep = 32'h7FFF_FFFF;
					default: dep = $urandom;
				endcase
				push_entry(tex, dep, k == size - 1, 1'b0);
				random_entries++;
			end
			await_set_records();
			set_no++;
		end
		steady = 1'b0;

		repeat (20) @(posedge clk);
		if (expected_records.size() != 0) begin
			note_mismatch($sformatf("%0d records never arrived", expected_records.size()));
		end
		$display("Covered %0d entries in %0d sets, %0d set(s) over capacity, sort modes seen %b.",
			entries_sent, sets_done, overflow_sets, modes_seen);
		$display("Checked %0d output records, %0d mismatch(es).", records_checked, mismatches);
		if (mismatches == 0) begin
			$display("stable_sort_and_batch_by_key regression: pass");
		end else begin
			$display("stable_sort_and_batch_by_key regression: fail");
		end
		$finish;
	end

endmodule
